@@ rtl/slrp_pkg.sv @@
// Shared types, constants and the tag lookup for the server list response parser.
package slrp_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 256;

  localparam logic [4:0] TAG_LEN    = 5'd18;
  localparam logic [2:0] RECORD_LEN = 3'd7;
  localparam logic [2:0] HEADER_FF_COUNT = 3'd4;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] RECORD_MARK = 8'h5C;          // backslash
  localparam logic [47:0] END_RECORD = 48'h454F54000000; // "EOT" then three zero bytes

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // One-hot parser phases.
  typedef enum logic [3:0] {
    PHASE_HEADER  = 4'b0001,
    PHASE_TAG     = 4'b0010,
    PHASE_RECORDS = 4'b0100,
    PHASE_IGNORE  = 4'b1000
  } phase_t;

  // Event from the parser to the output stage for one accepted word.
  typedef struct packed {
    logic        restart;
    logic        record;
    logic [31:0] ip;
    logic [15:0] port;
  } rec_event_t;

  function automatic logic [7:0] tag_char(input logic [4:0] pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = 8'h67; // g
      5'd1:    c = 8'h65; // e
      5'd2:    c = 8'h74; // t
      5'd3:    c = 8'h73; // s
      5'd4:    c = 8'h65; // e
      5'd5:    c = 8'h72; // r
      5'd6:    c = 8'h76; // v
      5'd7:    c = 8'h65; // e
      5'd8:    c = 8'h72; // r
      5'd9:    c = 8'h73; // s
      5'd10:   c = 8'h52; // R
      5'd11:   c = 8'h65; // e
      5'd12:   c = 8'h73; // s
      5'd13:   c = 8'h70; // p
      5'd14:   c = 8'h6F; // o
      5'd15:   c = 8'h6E; // n
      5'd16:   c = 8'h73; // s
      5'd17:   c = 8'h65; // e
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/server_list_response_parser_top.sv @@
// Server list response parser: one datagram word in, at most one server entry out, per cycle.
// Takes one byte (or restart) per cycle; the parser state updates in the cycle the word
// is accepted and a completed record appears in the result register on the next cycle.
// Throughput is one word per cycle, set by the single result register: in_ready drops
// only while a result waits and out_ready is low. A datagram may open with four 0xFF
// bytes, then must carry the tag, then 7-byte records (backslash, IPv4, port).
// Records beyond MAX_ENTRIES since the last restart are dropped; entry_index is the
// low eight bits of the entry's position.
module server_list_response_parser_top #(
  parameter int MAX_ENTRIES = slrp_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  entry_index,
  output logic [31:0] server_ip,
  output logic [15:0] server_port
);

  slrp_pkg::rec_event_t rec_event;
  logic                 step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  slrp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .operation (operation),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .event_out (rec_event)
  );

  slrp_out #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .event_in    (rec_event),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .entry_index (entry_index),
    .server_ip   (server_ip),
    .server_port (server_port)
  );

endmodule

@@ rtl/slrp_parser.sv @@
// Byte-level parser: header skip, tag match and record assembly.
module slrp_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    operation,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output slrp_pkg::rec_event_t    event_out
);

  slrp_pkg::phase_t phase, phase_next;
  logic [4:0]  match_position, match_position_next;
  logic [2:0]  record_fill, record_fill_next;
  logic [39:0] record_bytes, record_bytes_next;
  logic [47:0] full_record;
  logic        tag_hit;
  logic [4:0]  pos_inc;

  assign full_record = {record_bytes, data_byte};
  assign tag_hit = (match_position < slrp_pkg::TAG_LEN) &&
                   (data_byte == slrp_pkg::tag_char(match_position));
  assign pos_inc = match_position + 5'd1;

  always_comb begin
    phase_next          = phase;
    match_position_next = match_position;
    record_fill_next    = record_fill;
    record_bytes_next   = record_bytes;
    event_out.restart   = step && (operation == slrp_pkg::OP_RESTART);
    event_out.record    = 1'b0;
    event_out.ip        = full_record[47:16];
    event_out.port      = full_record[15:0];

    case (phase)
      slrp_pkg::PHASE_HEADER: begin
        if (data_byte == slrp_pkg::HEADER_BYTE) begin
          if (pos_inc >= {2'b00, slrp_pkg::HEADER_FF_COUNT}) begin
            match_position_next = '0;
            phase_next          = slrp_pkg::PHASE_TAG;
          end else begin
            match_position_next = pos_inc;
          end
        end else if (match_position == 5'd0) begin
          // No header: this byte opens the tag
          if (tag_hit) begin
            match_position_next = pos_inc;
            phase_next          = slrp_pkg::PHASE_TAG;
          end else begin
            phase_next = slrp_pkg::PHASE_IGNORE;
          end
        end else begin
          phase_next = slrp_pkg::PHASE_IGNORE;
        end
      end
      slrp_pkg::PHASE_TAG: begin
        if (tag_hit) begin
          match_position_next = pos_inc;
          if (pos_inc == slrp_pkg::TAG_LEN) begin
            phase_next       = slrp_pkg::PHASE_RECORDS;
            record_fill_next = '0;
          end
        end else begin
          phase_next = slrp_pkg::PHASE_IGNORE;
        end
      end
      slrp_pkg::PHASE_RECORDS: begin
        if (record_fill == 3'd0) begin
          if (data_byte != slrp_pkg::RECORD_MARK) begin
            phase_next = slrp_pkg::PHASE_IGNORE;
          end else begin
            record_fill_next = 3'd1;
          end
        end else begin
          record_bytes_next = full_record[39:0];
          if (record_fill == slrp_pkg::RECORD_LEN - 3'd1) begin
            record_fill_next = '0;
            if (full_record == slrp_pkg::END_RECORD) begin
              phase_next = slrp_pkg::PHASE_IGNORE;
            end else begin
              event_out.record = step && (operation == slrp_pkg::OP_BYTE);
            end
          end else begin
            record_fill_next = record_fill + 3'd1;
          end
        end
      end
      slrp_pkg::PHASE_IGNORE: begin
        phase_next = slrp_pkg::PHASE_IGNORE;
      end
      default: begin
        phase_next = slrp_pkg::PHASE_HEADER;
      end
    endcase

    // End of datagram or restart: back to the header phase
    if (last_byte || operation == slrp_pkg::OP_RESTART) begin
      phase_next          = slrp_pkg::PHASE_HEADER;
      match_position_next = '0;
      record_fill_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= slrp_pkg::PHASE_HEADER;
      match_position <= '0;
      record_fill    <= '0;
    end else if (step) begin
      phase          <= phase_next;
      match_position <= match_position_next;
      record_fill    <= record_fill_next;
    end
  end

  // Record payload needs no reset: five bytes are always shifted in before use
  always_ff @(posedge clk) begin
    if (step) begin
      record_bytes <= record_bytes_next;
    end
  end

endmodule

@@ rtl/slrp_out.sv @@
// Entry counter and result register.
module slrp_out #(
  parameter int MAX_ENTRIES = slrp_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  slrp_pkg::rec_event_t  event_in,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            entry_index,
  output logic [31:0]           server_ip,
  output logic [15:0]           server_port
);

  localparam int CNT_BITS = ($clog2(MAX_ENTRIES + 1) < 8) ? 8 : $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_BITS-1:0] COUNT_LIMIT = CNT_BITS'(MAX_ENTRIES);

  logic [CNT_BITS-1:0] stored_count;
  logic                store;

  assign store = event_in.record && (stored_count < COUNT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (event_in.restart) begin
        stored_count <= '0;
      end else if (store) begin
        stored_count <= stored_count + CNT_BITS'(1);
      end
      // A step is only taken when the result register is free or being drained
      if (step) begin
        out_valid <= store;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      entry_index <= stored_count[7:0];
      server_ip   <= event_in.ip;
      server_port <= event_in.port;
    end
  end

endmodule
